>>> hw/rtl/psq_pkg.sv
`default_nettype none
package psq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 7;
  localparam int VAL_W = 32;
  localparam int OP_W = 3;
  localparam int ST_W = 2;
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_MIDDLE = 3'd2,
    OP_POP    = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] rd_idx;
    logic [VAL_W-1:0] data;
  } cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/psq_cell.sv
`default_nettype none
module psq_cell (
  input  wire logic                      clk,
  input  wire psq_pkg::cmd_t             cmd,
  input  wire logic [psq_pkg::IDX_W-1:0] idx,
  input  wire logic [psq_pkg::VAL_W-1:0] left_val,
  input  wire logic [psq_pkg::VAL_W-1:0] right_val,
  output logic      [psq_pkg::VAL_W-1:0] val,
  output logic      [psq_pkg::VAL_W-1:0] rd_part
);

  logic [psq_pkg::VAL_W-1:0] val_r;
  logic [psq_pkg::VAL_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (cmd.ins) begin
      if (idx > cmd.slot) begin
        val_nxt = left_val;
      end else if (idx == cmd.slot) begin
        val_nxt = cmd.data;
      end
    end else if (cmd.pop) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  assign rd_part = (idx == cmd.rd_idx) ? val_r : '0;

endmodule
`default_nettype wire

>>> hw/rtl/psq_chain.sv
`default_nettype none
module psq_chain (
  input  wire logic                      clk,
  input  wire psq_pkg::cmd_t             cmd,
  output logic      [psq_pkg::VAL_W-1:0] rd_data
);

  logic [psq_pkg::VAL_W-1:0] vals  [psq_pkg::DEPTH];
  logic [psq_pkg::VAL_W-1:0] parts [psq_pkg::DEPTH];

  for (genvar i = 0; i < psq_pkg::DEPTH; i++) begin : g_cell
    logic [psq_pkg::VAL_W-1:0] left_v;
    logic [psq_pkg::VAL_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end

    if (i == psq_pkg::DEPTH - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end

    psq_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .idx       (psq_pkg::IDX_W'(i)),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (vals[i]),
      .rd_part   (parts[i])
    );
  end

  always_comb begin
    rd_data = '0;
    for (int k = 0; k < psq_pkg::DEPTH; k++) begin
      rd_data = rd_data | parts[k];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/positional_insert_sequence.sv
// Ordered sequence of up to 64 signed 32-bit values with insertion at any
// position. The input stream carries one operation per transfer: insert at
// a position, append, insert at the middle, pop the front, or read at a
// position. Every input transfer yields exactly one output transfer with
// the value popped or read, a status code and the count after the operation.
// The entries live in a row of cells that all shift in the same cycle. A
// result appears on the output in the cycle after its input transfer, and
// one operation per cycle is taken while the receiver keeps out_tready
// high. The output register holds one result; while it is full and the
// receiver stalls, in_tready is low and the held result stays unchanged.
// The cycle time is set by the read selection across all cells and the
// shift decode in each cell. Reset empties the sequence and drops any
// pending result; no clearing pass is needed, since only entries below
// the count are ever read.
`default_nettype none
module positional_insert_sequence (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // op [2:0], position [9:3], value_in [41:10], zero fill above.
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // value_out [31:0], status [33:32], count [40:34], zero fill above.
  output logic      [47:0] out_tdata
);

  logic                      in_fire;
  psq_pkg::op_t              op;
  logic [psq_pkg::POS_W-1:0] position;
  logic [psq_pkg::VAL_W-1:0] value_in;

  logic [psq_pkg::CNT_W-1:0] count_r;
  logic [psq_pkg::CNT_W-1:0] count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [psq_pkg::VAL_W-1:0] out_value_r;
  logic [psq_pkg::VAL_W-1:0] out_value_nxt;
  psq_pkg::status_t          out_status_r;
  psq_pkg::status_t          out_status_nxt;
  logic [psq_pkg::CNT_W-1:0] out_count_r;

  psq_pkg::cmd_t             cmd;
  logic [psq_pkg::VAL_W-1:0] rd_data;
  logic                      full;
  logic                      empty;
  logic [psq_pkg::CMP_W-1:0] pos_ext;
  logic [psq_pkg::CMP_W-1:0] cnt_ext;
  logic [psq_pkg::CNT_W-1:0] mid_slot;

  assign op       = psq_pkg::op_t'(in_tdata[2:0]);
  assign position = in_tdata[9:3];
  assign value_in = in_tdata[41:10];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign full     = (count_r == psq_pkg::CNT_W'(psq_pkg::DEPTH));
  assign empty    = (count_r == '0);
  assign pos_ext  = psq_pkg::CMP_W'(position);
  assign cnt_ext  = psq_pkg::CMP_W'(count_r);
  assign mid_slot = psq_pkg::CNT_W'((psq_pkg::CNT_W + 1)'(count_r) + 1'b1 >> 1);

  always_comb begin
    cmd            = '0;
    cmd.data       = value_in;
    cmd.rd_idx     = psq_pkg::IDX_W'(position);
    count_nxt      = count_r;
    out_value_nxt  = '0;
    out_status_nxt = psq_pkg::ST_OK;
    unique case (op)
      psq_pkg::OP_INSERT, psq_pkg::OP_APPEND, psq_pkg::OP_MIDDLE: begin
        if (full) begin
          out_status_nxt = psq_pkg::ST_FULL;
        end else begin
          cmd.ins   = in_fire;
          count_nxt = count_r + 1'b1;
          if (op == psq_pkg::OP_MIDDLE) begin
            cmd.slot = psq_pkg::IDX_W'(mid_slot);
          end else if (op == psq_pkg::OP_INSERT && pos_ext <= cnt_ext) begin
            cmd.slot = psq_pkg::IDX_W'(position);
          end else begin
            cmd.slot = psq_pkg::IDX_W'(count_r);
          end
        end
      end
      psq_pkg::OP_POP: begin
        cmd.rd_idx = '0;
        if (empty) begin
          out_status_nxt = psq_pkg::ST_EMPTY;
        end else begin
          cmd.pop       = in_fire;
          count_nxt     = count_r - 1'b1;
          out_value_nxt = rd_data;
        end
      end
      psq_pkg::OP_READ: begin
        if (empty) begin
          out_status_nxt = psq_pkg::ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          out_status_nxt = psq_pkg::ST_RANGE;
        end else begin
          out_value_nxt = rd_data;
        end
      end
      default: begin
      end
    endcase
  end

  psq_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .rd_data (rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, 7'(out_count_r), out_status_r, out_value_r};

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= psq_pkg::CNT_W'(psq_pkg::DEPTH))
    else $error("sequence count exceeds its depth");

  a_insert_grows : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.ins) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the count by one");

  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == psq_pkg::ST_FULL) |->
      (out_count_r == psq_pkg::CNT_W'(psq_pkg::DEPTH)))
    else $error("full status reported with a count below depth");

  a_empty_count : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == psq_pkg::ST_EMPTY) |-> (out_count_r == '0))
    else $error("empty status reported with a nonzero count");

endmodule
`default_nettype wire
